/* rtl/sefr_pkg.sv */
// Types, codes and constants shared by the STX/ETX frame receiver.
package sefr_pkg;

  localparam logic [7:0] BYTE_STX = 8'h02;
  localparam logic [7:0] BYTE_ETX = 8'h03;

  localparam logic [31:0] CMD_WORD_PING = 32'h474e_4950;
  localparam logic [31:0] CMD_WORD_CSET = 32'h5445_5343;
  localparam logic [31:0] CMD_WORD_CGET = 32'h5445_4743;
  localparam logic [31:0] CMD_WORD_HGET = 32'h5445_4748;
  localparam logic [31:0] CMD_WORD_LIVE = 32'h4556_494c;

  // result kinds
  localparam logic [1:0] KIND_ECHO     = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD  = 2'd1;
  localparam logic [1:0] KIND_COMPLETE = 2'd2;
  localparam logic [1:0] KIND_DROP     = 2'd3;

  // decoded commands
  localparam logic [2:0] CMD_PING    = 3'd0;
  localparam logic [2:0] CMD_CSET    = 3'd1;
  localparam logic [2:0] CMD_CGET    = 3'd2;
  localparam logic [2:0] CMD_HGET    = 3'd3;
  localparam logic [2:0] CMD_LIVE    = 3'd4;
  localparam logic [2:0] CMD_UNKNOWN = 3'd5;

  // receiver phases
  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_CMD  = 3'd1;
  localparam logic [2:0] PH_LEN  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_SUM  = 3'd4;
  localparam logic [2:0] PH_ETX  = 3'd5;

  typedef struct packed {
    logic [2:0]  phase;
    logic [1:0]  header_count;
    logic [31:0] command_bytes;
    logic [7:0]  announced_length;
    logic [7:0]  payload_position;
    logic [6:0]  running_sum;
    logic [7:0]  received_checksum;
  } sefr_state_t;

  localparam sefr_state_t STATE_RESET = '{
    phase:             PH_HUNT,
    header_count:      2'd0,
    command_bytes:     32'd0,
    announced_length:  8'd0,
    payload_position:  8'd0,
    running_sum:       7'd0,
    received_checksum: 8'd0
  };

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [7:0]  payload_index;
    logic [2:0]  command_code;
    logic [31:0] command_raw;
    logic [7:0]  frame_length;
    logic        checksum_ok;
  } sefr_result_t;

  function automatic logic [2:0] decode_command(input logic [31:0] raw);
    logic [2:0] code;
    case (raw)
      CMD_WORD_PING: code = CMD_PING;
      CMD_WORD_CSET: code = CMD_CSET;
      CMD_WORD_CGET: code = CMD_CGET;
      CMD_WORD_HGET: code = CMD_HGET;
      CMD_WORD_LIVE: code = CMD_LIVE;
      default:       code = CMD_UNKNOWN;
    endcase
    return code;
  endfunction

endpackage

/* rtl/sefr_in_if.sv */
// Received-byte channel: valid/ready handshake with one byte of payload.
interface sefr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/sefr_out_if.sv */
// Result channel: valid/ready handshake with the decoded frame fields.
interface sefr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  byte_value;
  logic [7:0]  payload_index;
  logic [2:0]  command_code;
  logic [31:0] command_raw;
  logic [7:0]  frame_length;
  logic        checksum_ok;

  modport source (output valid, output kind, output byte_value, output payload_index,
                  output command_code, output command_raw, output frame_length,
                  output checksum_ok, input ready);
  modport sink   (input valid, input kind, input byte_value, input payload_index,
                  input command_code, input command_raw, input frame_length,
                  input checksum_ok, output ready);
endinterface

/* rtl/sefr_parser.sv */
// Next-state and result logic of the frame receiver for one received byte.
module sefr_parser (
  input  sefr_pkg::sefr_state_t  cur,
  input  logic [7:0]             rx_byte,
  output sefr_pkg::sefr_state_t  nxt,
  output logic                   res_valid,
  output sefr_pkg::sefr_result_t res
);
  import sefr_pkg::*;

  logic [7:0] pos_inc;

  assign pos_inc = cur.payload_position + 8'd1;

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res       = '0;
    case (cur.phase)
      PH_CMD: begin
        case (cur.header_count)
          2'd0:    nxt.command_bytes[7:0]   = cur.command_bytes[7:0]   | rx_byte;
          2'd1:    nxt.command_bytes[15:8]  = cur.command_bytes[15:8]  | rx_byte;
          2'd2:    nxt.command_bytes[23:16] = cur.command_bytes[23:16] | rx_byte;
          default: nxt.command_bytes[31:24] = cur.command_bytes[31:24] | rx_byte;
        endcase
        nxt.running_sum = cur.running_sum ^ rx_byte[6:0];
        if (cur.header_count == 2'd3) begin
          nxt.header_count = 2'd0;
          nxt.phase        = PH_LEN;
        end else begin
          nxt.header_count = cur.header_count + 2'd1;
        end
      end
      PH_LEN: begin
        nxt.announced_length = rx_byte;
        nxt.payload_position = 8'd0;
        nxt.phase            = (rx_byte == 8'd0) ? PH_SUM : PH_DATA;
      end
      PH_DATA: begin
        nxt.running_sum      = cur.running_sum + rx_byte[6:0];
        nxt.payload_position = pos_inc;
        if (pos_inc >= cur.announced_length) begin
          nxt.phase = PH_SUM;
        end
        res_valid         = 1'b1;
        res.kind          = KIND_PAYLOAD;
        res.byte_value    = rx_byte;
        res.payload_index = cur.payload_position;
      end
      PH_SUM: begin
        nxt.received_checksum = rx_byte;
        nxt.phase             = PH_ETX;
      end
      PH_ETX: begin
        nxt.phase = PH_HUNT;
        res_valid = 1'b1;
        if (rx_byte != BYTE_ETX) begin
          res.kind = KIND_DROP;
        end else begin
          res.kind         = KIND_COMPLETE;
          res.command_code = decode_command(cur.command_bytes);
          res.command_raw  = cur.command_bytes;
          res.frame_length = cur.announced_length;
          // 7-bit sum never matches a checksum byte with bit 7 set
          res.checksum_ok  = !cur.received_checksum[7] &&
                             (cur.received_checksum[6:0] == cur.running_sum);
        end
      end
      default: begin
        nxt.phase = PH_HUNT;
        if (rx_byte == BYTE_STX) begin
          nxt       = STATE_RESET;
          nxt.phase = PH_CMD;
        end else begin
          res_valid      = 1'b1;
          res.kind       = KIND_ECHO;
          res.byte_value = rx_byte;
        end
      end
    endcase
  end

endmodule

/* rtl/stx_etx_frame_receiver_unit.sv */
// STX/ETX frame receiver: echo outside frames, payload pass-through, frame report.
//
//   channel   dir  payload                                    transfer when
//   in_ch     in   rx_byte                                    valid && ready
//   out_ch    out  kind, byte_value, payload_index,           valid && ready
//                  command_code, command_raw, frame_length,
//                  checksum_ok
//
// One byte per cycle while in_ch.ready is high; a result is registered at the
// input transfer of its byte. Receiver state updates at the input transfer.
// in_ch.ready drops only while a held result is not taken (output register).
// Synchronous reset returns the receiver to hunting for STX.
module stx_etx_frame_receiver_unit (
  input logic       clk,
  input logic       rst_n,
  sefr_in_if.sink   in_ch,
  sefr_out_if.source out_ch
);
  import sefr_pkg::*;

  sefr_state_t  state_r;
  sefr_state_t  state_nxt;
  logic         res_valid;
  sefr_result_t res;
  logic         out_valid_r;
  sefr_result_t out_r;
  logic         in_xfer;

  sefr_parser u_parser (
    .cur       (state_r),
    .rx_byte   (in_ch.rx_byte),
    .nxt       (state_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_r     <= state_nxt;
        out_valid_r <= res_valid;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = out_r.kind;
  assign out_ch.byte_value    = out_r.byte_value;
  assign out_ch.payload_index = out_r.payload_index;
  assign out_ch.command_code  = out_r.command_code;
  assign out_ch.command_raw   = out_r.command_raw;
  assign out_ch.frame_length  = out_r.frame_length;
  assign out_ch.checksum_ok   = out_r.checksum_ok;

endmodule

/* tb/sefr_frame_check.sv */
// Watches both channels, predicts each frame receiver result and compares it field by field.
module sefr_frame_check (
  input  logic clk,
  input  logic rst_n,
  sefr_in_if   in_mon,
  sefr_out_if  out_mon,
  output int   mismatches,
  output int   awaited,
  output int   echo_seen,
  output int   payload_seen,
  output int   complete_seen,
  output int   nack_seen,
  output int   drop_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import sefr_pkg::*;

  // receiver state as predicted
  logic [2:0]  rx_phase;
  logic [1:0]  hdr_cnt;
  logic [31:0] cmd_word;
  logic [7:0]  frame_len;
  logic [7:0]  data_idx;
  logic [6:0]  sum_calc;
  logic [7:0]  sum_rcvd;

  sefr_result_t pending_results[$];

  task automatic note_failure(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Advance the receiver by one byte; emits is low when the byte yields no result.
  function automatic void take_byte(input logic [7:0] b, output logic emits,
                                    output sefr_result_t res);
    res   = '0;
    emits = 1'b1;
    case (rx_phase)
      PH_CMD: begin
        cmd_word[8*hdr_cnt +: 8] = b;
        sum_calc = sum_calc ^ b[6:0];
        if (hdr_cnt == 2'd3) rx_phase = PH_LEN;
        hdr_cnt = hdr_cnt + 2'd1;
        emits = 1'b0;
      end
      PH_LEN: begin
        frame_len = b;
        data_idx  = 8'd0;
        rx_phase  = (b == 8'd0) ? PH_SUM : PH_DATA;
        emits     = 1'b0;
      end
      PH_DATA: begin
        sum_calc          = sum_calc + b[6:0];
        res.kind          = KIND_PAYLOAD;
        res.byte_value    = b;
        res.payload_index = data_idx;
        data_idx          = data_idx + 8'd1;
        if (data_idx >= frame_len) rx_phase = PH_SUM;
      end
      PH_SUM: begin
        sum_rcvd = b;
        rx_phase = PH_ETX;
        emits    = 1'b0;
      end
      PH_ETX: begin
        rx_phase = PH_HUNT;
        if (b != BYTE_ETX) begin
          res.kind = KIND_DROP;
        end else begin
          res.kind = KIND_COMPLETE;
          case (cmd_word)
            CMD_WORD_PING: res.command_code = CMD_PING;
            CMD_WORD_CSET: res.command_code = CMD_CSET;
            CMD_WORD_CGET: res.command_code = CMD_CGET;
            CMD_WORD_HGET: res.command_code = CMD_HGET;
            CMD_WORD_LIVE: res.command_code = CMD_LIVE;
            default:       res.command_code = CMD_UNKNOWN;
          endcase
          res.command_raw  = cmd_word;
          res.frame_length = frame_len;
          // bit 7 of the received checksum can never match the 7-bit sum
          res.checksum_ok  = ({1'b0, sum_calc} == sum_rcvd);
        end
      end
      default: begin
        rx_phase = PH_HUNT;
        if (b == BYTE_STX) begin
          rx_phase  = PH_CMD;
          hdr_cnt   = 2'd0;
          cmd_word  = 32'd0;
          frame_len = 8'd0;
          data_idx  = 8'd0;
          sum_calc  = 7'd0;
          sum_rcvd  = 8'd0;
          emits     = 1'b0;
        end else begin
          res.kind       = KIND_ECHO;
          res.byte_value = b;
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    sefr_result_t want;
    logic         emits;
    if (!rst_n) begin
      rx_phase  = PH_HUNT;
      hdr_cnt   = 2'd0;
      cmd_word  = 32'd0;
      frame_len = 8'd0;
      data_idx  = 8'd0;
      sum_calc  = 7'd0;
      sum_rcvd  = 8'd0;
      pending_results.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        take_byte(in_mon.rx_byte, emits, want);
        if (emits) pending_results.push_back(want);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          note_failure($sformatf("result transfer with nothing expected (kind %0d)",
                                 out_mon.kind));
        end else begin
          want = pending_results.pop_front();
          if (out_mon.kind !== want.kind)
            note_failure($sformatf("kind got %0d, expected %0d", out_mon.kind, want.kind));
          if (out_mon.byte_value !== want.byte_value)
            note_failure($sformatf("byte_value got 0x%0h, expected 0x%0h",
                                   out_mon.byte_value, want.byte_value));
          if (out_mon.payload_index !== want.payload_index)
            note_failure($sformatf("payload_index got %0d, expected %0d",
                                   out_mon.payload_index, want.payload_index));
          if (out_mon.command_code !== want.command_code)
            note_failure($sformatf("command_code got %0d, expected %0d",
                                   out_mon.command_code, want.command_code));
          if (out_mon.command_raw !== want.command_raw)
            note_failure($sformatf("command_raw got 0x%0h, expected 0x%0h",
                                   out_mon.command_raw, want.command_raw));
          if (out_mon.frame_length !== want.frame_length)
            note_failure($sformatf("frame_length got %0d, expected %0d",
                                   out_mon.frame_length, want.frame_length));
          if (out_mon.checksum_ok !== want.checksum_ok)
            note_failure($sformatf("checksum_ok got %0d, expected %0d",
                                   out_mon.checksum_ok, want.checksum_ok));
          case (want.kind)
            KIND_ECHO:    echo_seen++;
            KIND_PAYLOAD: payload_seen++;
            KIND_COMPLETE: begin
              complete_seen++;
              if (!want.checksum_ok) nack_seen++;
            end
            default:      drop_seen++;
          endcase
        end
      end
    end
    awaited <= pending_results.size();
  end

endmodule

/* tb/stx_etx_frame_receiver_unit_test.sv */
// Top of the frame receiver testbench: clock, reset, byte stimulus, result stalls, verdict.
module stx_etx_frame_receiver_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sefr_pkg::*;

  localparam int ITEM_TARGET   = 1850;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AFTER    = 400;
  localparam int IDLE_LIMIT    = 3000;
  localparam int DRAIN_CYCLES  = 8;

  typedef enum {SUM_GOOD, SUM_RANDOM, SUM_BIT7} sum_style_t;

  logic clk = 1'b0;
  logic rst_n;

  sefr_in_if  in_ch ();
  sefr_out_if out_ch ();

  int mismatches, awaited;
  int echo_seen, payload_seen, complete_seen, nack_seen, drop_seen;

  int   bytes_sent   = 0;
  int   in_xfers     = 0;
  int   idle_cycles  = 0;
  int   steady_left  = 0;
  logic pressure_on  = 1'b0;
  logic long_done    = 1'b0;

  stx_etx_frame_receiver_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sefr_frame_check frame_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .mismatches    (mismatches),
    .awaited       (awaited),
    .echo_seen     (echo_seen),
    .payload_seen  (payload_seen),
    .complete_seen (complete_seen),
    .nack_seen     (nack_seen),
    .drop_seen     (drop_seen)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (in_ch.valid && in_ch.ready) in_xfers <= in_xfers + 1;
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
             IDLE_LIMIT, awaited);
    $display("Verification failed");
    $finish;
  end

  // Sender gaps: mostly none or short, a few long, with steady stretches.
  function automatic int pick_gap();
    int r;
    if (pressure_on) return 0;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      steady_left = $urandom_range(30, 120);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid   <= 1'b0;
      in_ch.rx_byte <= 8'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [31:0] cmd, input int len,
                            input sum_style_t style, input logic [7:0] tail);
    logic [6:0] sum;
    logic [7:0] d;
    logic [7:0] ck;
    sum = cmd[6:0] ^ cmd[14:8] ^ cmd[22:16] ^ cmd[30:24];
    send_byte(BYTE_STX);
    for (int i = 0; i < 4; i++) send_byte(cmd[8*i +: 8]);
    send_byte(8'(len));
    for (int i = 0; i < len; i++) begin
      // frame markers inside the payload are plain data
      if ($urandom_range(0, 9) == 0) d = $urandom_range(0, 1) ? BYTE_STX : BYTE_ETX;
      else d = 8'($urandom);
      sum = sum + d[6:0];
      send_byte(d);
    end
    case (style)
      SUM_GOOD:   ck = {1'b0, sum};
      SUM_BIT7:   ck = {1'b1, sum};
      default:    ck = 8'($urandom);
    endcase
    send_byte(ck);
    send_byte(tail);
  endtask

  // Result side: random ready with one long hold-off once traffic is going.
  initial begin : result_taker
    int run;
    int stall;
    int r;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!long_done && in_xfers >= HOLD_AFTER) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        pressure_on  <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        pressure_on  <= 1'b0;
        long_done = 1'b1;
      end
      r = $urandom_range(0, 99);
      run = (r < 15) ? $urandom_range(40, 150) : $urandom_range(1, 8);
      @(negedge clk);
      out_ch.ready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      r = $urandom_range(0, 99);
      if (r < 30)      stall = 0;
      else if (r < 88) stall = $urandom_range(1, 3);
      else             stall = $urandom_range(8, 40);
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  initial begin : byte_source
    int          pick;
    int          len;
    logic [31:0] cmd;
    logic [7:0]  b;
    logic [7:0]  tail;
    sum_style_t  style;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'd0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: echo extremes, ETX while hunting, a bare PING,
    // markers in the command with checksum bit 7 set, and a dropped frame
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(BYTE_ETX);
    send_frame(CMD_WORD_PING, 0, SUM_GOOD, BYTE_ETX);
    send_frame(32'h0302_0302, 1, SUM_BIT7, BYTE_ETX);
    send_frame(CMD_WORD_LIVE, 1, SUM_GOOD, BYTE_STX);

    while (bytes_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        case ($urandom_range(0, 6))
          0:       cmd = CMD_WORD_PING;
          1:       cmd = CMD_WORD_CSET;
          2:       cmd = CMD_WORD_CGET;
          3:       cmd = CMD_WORD_HGET;
          4:       cmd = CMD_WORD_LIVE;
          5:       cmd = $urandom;
          default: cmd = CMD_WORD_CGET ^ (32'h1 << $urandom_range(0, 31));
        endcase
        pick = $urandom_range(0, 99);
        if (!long_done && bytes_sent >= 900) len = 255;
        else if (pick < 2)  len = 255;
        else if (pick < 10) len = $urandom_range(13, 64);
        else                len = $urandom_range(0, 12);
        pick = $urandom_range(0, 99);
        style = (pick < 70) ? SUM_GOOD : (pick < 85) ? SUM_RANDOM : SUM_BIT7;
        if ($urandom_range(0, 9) == 0) begin
          do tail = 8'($urandom); while (tail == BYTE_ETX);
        end else begin
          tail = BYTE_ETX;
        end
        send_frame(cmd, len, style, tail);
      end else if (pick < 93) begin
        repeat ($urandom_range(1, 4)) begin
          do b = 8'($urandom); while (b == BYTE_STX);
          send_byte(b);
        end
      end else begin
        // truncated frame: small bytes keep any announced length short
        send_byte(BYTE_STX);
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 15)));
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes; checked %0d echoes, %0d payload bytes, %0d dropped frames",
             bytes_sent, echo_seen, payload_seen, drop_seen);
    $display("%0d complete frames (%0d checksum mismatches), one %0d-cycle result hold-off",
             complete_seen, nack_seen, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sefr_pkg.sv
rtl/sefr_in_if.sv
rtl/sefr_out_if.sv
rtl/sefr_parser.sv
rtl/stx_etx_frame_receiver_unit.sv
tb/sefr_frame_check.sv
tb/stx_etx_frame_receiver_unit_test.sv
